// File: hw/rtl/pqsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqsi_pkg: shared types and constants of the sorted-insert priority queue
// Payload structs, status and operation codes, sequencer states.
// ----------------------------------------------------------------------------
package pqsi_pkg;

	localparam int QUEUE_DEPTH    = 16;
	localparam int VALUE_WIDTH    = 32;
	localparam int PRIORITY_WIDTH = 8;
	localparam int COUNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W          = $clog2(QUEUE_DEPTH);

	localparam logic [PRIORITY_WIDTH-1:0] HIGHEST_PRIORITY_RST = '1;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_PRIO_HIGH  = 2'd1,
		STATUS_POP_EMPTY  = 2'd2,
		STATUS_PUSH_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_WALK,
		ST_PUSH_PLACE,
		ST_POP_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                      kind;
		logic [VALUE_WIDTH-1:0]    item_value;
		logic [PRIORITY_WIDTH-1:0] item_priority;
	} cmd_t;

	typedef struct packed {
		status_t                   status;
		logic [VALUE_WIDTH-1:0]    head_value;
		logic [PRIORITY_WIDTH-1:0] head_priority;
		logic                      is_empty;
		logic [COUNT_W-1:0]        entry_count;
	} rsp_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0]    value;
		logic [PRIORITY_WIDTH-1:0] prio;
	} entry_t;

endpackage

// File: hw/rtl/pqsi_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqsi_slot_ram: slot store of the priority queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pqsi_slot_ram #(
	parameter int DEPTH = pqsi_pkg::QUEUE_DEPTH,
	parameter int WIDTH = $bits(pqsi_pkg::entry_t)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/priority_queue_sorted_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_queue_sorted_insert: bounded priority queue by sorted insertion
// Slots held in descending priority order, slot 0 is the head; equal
// priorities leave first-in first-out. One slot moves per cycle.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  --------  -----------------------------  -----------------------------------
//  command   start, busy, item (cmd_t)      taken when start && !busy
//  result    done, result (rsp_t)           one-cycle strobe, no backpressure
//  config    cfg_valid, cfg_ready, cfg_data written when cfg_valid && cfg_ready
//
//  A push walks from the tail toward the head until it finds its slot; a pop
//  moves every entry up by one slot. A rejected item, a push into an empty
//  queue and a pop of at most one entry go straight to the done state. The
//  walk through the slot store reads one slot and writes one per cycle.
//  Reset empties the queue and sets highest_priority to its maximum.
//  Results cannot be stalled; busy holds off the next command.
// ----------------------------------------------------------------------------
module priority_queue_sorted_insert (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  pqsi_pkg::cmd_t                             item,
	output logic                                       done,
	output pqsi_pkg::rsp_t                             result,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [pqsi_pkg::PRIORITY_WIDTH-1:0]        cfg_data
);

	localparam int IDX_W   = pqsi_pkg::IDX_W;
	localparam int COUNT_W = pqsi_pkg::COUNT_W;
	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(pqsi_pkg::QUEUE_DEPTH);

	pqsi_pkg::state_t  state_q, state_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [COUNT_W-1:0] occ_q, occ_d;
	pqsi_pkg::entry_t  head_q, head_d;
	pqsi_pkg::entry_t  new_q, new_d;
	pqsi_pkg::status_t status_q, status_d;
	logic [pqsi_pkg::PRIORITY_WIDTH-1:0] highest_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_raddr;
	pqsi_pkg::entry_t  ram_wdata;
	pqsi_pkg::entry_t  ram_rdata;

	logic              take;
	logic              prio_high;
	logic              full;
	logic              rd_keeps;
	logic              walk_last;
	pqsi_pkg::entry_t  item_entry;

	assign take       = start && !busy;
	assign prio_high  = item.item_priority > highest_q;
	assign full       = occ_q == FULL_COUNT;
	assign rd_keeps   = ram_rdata.prio >= new_q.prio;
	assign walk_last  = {1'b0, idx_q} == COUNT_W'(occ_q - COUNT_W'(1));
	assign item_entry = '{value: item.item_value, prio: item.item_priority};

	pqsi_slot_ram #(
		.DEPTH(pqsi_pkg::QUEUE_DEPTH),
		.WIDTH($bits(pqsi_pkg::entry_t))
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pqsi_pkg::ST_IDLE: begin
				if (take) begin
					if (item.kind == pqsi_pkg::KIND_PUSH) begin
						if (prio_high || full || occ_q == '0) begin
							state_d = pqsi_pkg::ST_DONE;
						end else begin
							state_d = pqsi_pkg::ST_PUSH_WALK;
						end
					end else if (occ_q <= COUNT_W'(1)) begin
						state_d = pqsi_pkg::ST_DONE;
					end else begin
						state_d = pqsi_pkg::ST_POP_WALK;
					end
				end
			end
			pqsi_pkg::ST_PUSH_WALK: begin
				if (rd_keeps) begin
					state_d = pqsi_pkg::ST_DONE;
				end else if (idx_q == '0) begin
					state_d = pqsi_pkg::ST_PUSH_PLACE;
				end
			end
			pqsi_pkg::ST_PUSH_PLACE: state_d = pqsi_pkg::ST_DONE;
			pqsi_pkg::ST_POP_WALK: begin
				if (walk_last) begin
					state_d = pqsi_pkg::ST_DONE;
				end
			end
			pqsi_pkg::ST_DONE: state_d = pqsi_pkg::ST_IDLE;
			default: state_d = pqsi_pkg::ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(idx_q + IDX_W'(1));
		ram_wdata = new_q;
		ram_raddr = idx_q;
		idx_d     = idx_q;
		occ_d     = occ_q;
		head_d    = head_q;
		new_d     = new_q;
		status_d  = status_q;
		case (state_q)
			pqsi_pkg::ST_IDLE: begin
				if (take) begin
					new_d    = item_entry;
					status_d = pqsi_pkg::STATUS_OK;
					if (item.kind == pqsi_pkg::KIND_PUSH) begin
						if (prio_high) begin
							status_d = pqsi_pkg::STATUS_PRIO_HIGH;
						end else if (full) begin
							status_d = pqsi_pkg::STATUS_PUSH_FULL;
						end else begin
							occ_d = COUNT_W'(occ_q + COUNT_W'(1));
							if (occ_q == '0) begin
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = item_entry;
								head_d    = item_entry;
							end else begin
								// start at the tail and walk toward the head
								idx_d     = IDX_W'(occ_q - COUNT_W'(1));
								ram_raddr = IDX_W'(occ_q - COUNT_W'(1));
							end
						end
					end else begin
						if (occ_q == '0) begin
							status_d = pqsi_pkg::STATUS_POP_EMPTY;
						end else if (occ_q == COUNT_W'(1)) begin
							occ_d = '0;
						end else begin
							idx_d     = IDX_W'(1);
							ram_raddr = IDX_W'(1);
						end
					end
				end
			end
			pqsi_pkg::ST_PUSH_WALK: begin
				ram_we = 1'b1;
				if (!rd_keeps) begin
					// shift the lower-priority entry back by one slot
					ram_wdata = ram_rdata;
					if (idx_q != '0) begin
						idx_d     = IDX_W'(idx_q - IDX_W'(1));
						ram_raddr = IDX_W'(idx_q - IDX_W'(1));
					end
				end
			end
			pqsi_pkg::ST_PUSH_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				head_d    = new_q;
			end
			pqsi_pkg::ST_POP_WALK: begin
				// move each entry up by one slot
				ram_we    = 1'b1;
				ram_waddr = IDX_W'(idx_q - IDX_W'(1));
				ram_wdata = ram_rdata;
				if (idx_q == IDX_W'(1)) begin
					head_d = ram_rdata;
				end
				if (walk_last) begin
					occ_d = COUNT_W'(occ_q - COUNT_W'(1));
				end else begin
					idx_d     = IDX_W'(idx_q + IDX_W'(1));
					ram_raddr = IDX_W'(idx_q + IDX_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pqsi_pkg::ST_IDLE;
			occ_q     <= '0;
			highest_q <= pqsi_pkg::HIGHEST_PRIORITY_RST;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			if (cfg_valid && cfg_ready) begin
				highest_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		head_q   <= head_d;
		new_q    <= new_d;
		status_q <= status_d;
	end

	assign busy      = state_q != pqsi_pkg::ST_IDLE;
	assign done      = state_q == pqsi_pkg::ST_DONE;
	assign cfg_ready = 1'b1;

	always_comb begin
		result.status        = status_q;
		result.is_empty      = occ_q == '0;
		result.entry_count   = occ_q;
		result.head_value    = (occ_q == '0) ? '0 : head_q.value;
		result.head_priority = (occ_q == '0) ? '0 : head_q.prio;
	end

endmodule
